FILE: rtl/core/spq_pkg.sv
// shared types and constants for the sorted priority queue
package spq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;

    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int KEY_W       = 16;
    localparam int TAG_W       = 16;
    localparam int ITEMS_W     = 8;
    localparam int COUNT_OUT_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic               shopper;
        logic [ITEMS_W-1:0] items;
    } t_entry;

    typedef struct packed {
        logic                load;
        logic                rd_prev;
        logic                rd_head;
        logic                wr_shift;
        logic                wr_new;
        logic                resp;
        logic [STATUS_W-1:0] resp_status;
        logic                resp_head;
        logic                pop;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_is_one;
        logic key_gt;
    } t_dp_stat;

endpackage

FILE: rtl/core/sorted_priority_queue_top.sv
// Min-key priority queue held sorted in a ring-addressed memory of QUEUE_DEPTH entries.
// A request is taken when start is high and busy is low; its single result appears on the
// o_ ports in the cycle after its last cycle of work (the cycle busy falls, or the cycle
// after acceptance when busy never rises), marked by o_valid for exactly one cycle, and
// must be captured then since it cannot be held off. Rejected inserts (full), pops or
// peeks on an empty queue and unused command codes give their result without raising
// busy. A pop or peek goes through a head read state, then an output state (one registered
// memory read). An insert walks from the tail toward the head one entry at a time (read,
// then compare and shift up) and writes the new entry just after the nearest stored key
// not above it, or at the head in a put state, which an insert on an empty queue enters
// at once. Equal keys leave in arrival order.
module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [spq_pkg::CMD_W-1:0]           i_command,
    input  logic [spq_pkg::KEY_W-1:0]           i_key,
    input  logic [spq_pkg::TAG_W-1:0]           i_entry_tag,
    input  logic                                i_shopper_flag,
    input  logic [spq_pkg::ITEMS_W-1:0]         i_item_count,
    output logic                                o_valid,
    output logic [spq_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_head_valid,
    output logic [spq_pkg::KEY_W-1:0]           o_head_key,
    output logic [spq_pkg::TAG_W-1:0]           o_head_tag,
    output logic                                o_head_shopper,
    output logic [spq_pkg::ITEMS_W-1:0]         o_head_items,
    output logic [spq_pkg::COUNT_OUT_W-1:0]     o_entry_count
);
    import spq_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    spq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_key          (i_key),
        .i_entry_tag    (i_entry_tag),
        .i_shopper_flag (i_shopper_flag),
        .i_item_count   (i_item_count),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_head_valid   (o_head_valid),
        .o_head_key     (o_head_key),
        .o_head_tag     (o_head_tag),
        .o_head_shopper (o_head_shopper),
        .o_head_items   (o_head_items),
        .o_entry_count  (o_entry_count)
    );

`ifndef SYNTHESIS
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) || $past(start))
        else $error("result without a request in progress");

    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("accepted request neither worked on nor answered");

    a_head_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_head_valid |-> o_status == ST_OK)
        else $error("head returned with error status");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_entry_count == '0)
        else $error("empty status with nonzero count");
`endif

endmodule

FILE: rtl/core/spq_datapath.sv
// entry memory, ring pointers, insert index and result registers
module spq_datapath #(
    parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_dp_cmd                    i_cmd,
    output spq_pkg::t_dp_stat                   o_stat,
    input  logic [spq_pkg::KEY_W-1:0]           i_key,
    input  logic [spq_pkg::TAG_W-1:0]           i_entry_tag,
    input  logic                                i_shopper_flag,
    input  logic [spq_pkg::ITEMS_W-1:0]         i_item_count,
    output logic                                o_valid,
    output logic [spq_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_head_valid,
    output logic [spq_pkg::KEY_W-1:0]           o_head_key,
    output logic [spq_pkg::TAG_W-1:0]           o_head_tag,
    output logic                                o_head_shopper,
    output logic [spq_pkg::ITEMS_W-1:0]         o_head_items,
    output logic [spq_pkg::COUNT_OUT_W-1:0]     o_entry_count
);
    import spq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry          r_mem [QUEUE_DEPTH];
    t_entry          r_rd;
    t_entry          r_new;
    logic [AW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic [CW-1:0]   r_idx;
    logic [AW-1:0]   w_addr;
    logic [AW-1:0]   rd_addr;
    logic            we;
    t_entry          w_data;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW+1)'(off);
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign o_stat.empty      = (r_count == '0);
    assign o_stat.full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.idx_is_one = (r_idx == CW'(1));
    assign o_stat.key_gt     = (r_rd.key > r_new.key);

    assign w_addr  = f_phys(r_head, r_idx);
    assign rd_addr = i_cmd.rd_head ? r_head : f_phys(r_head, r_idx - CW'(1));
    assign we      = i_cmd.wr_shift | i_cmd.wr_new;
    assign w_data  = i_cmd.wr_shift ? r_rd : r_new;

    always_comb begin
        n_count = r_count;
        if (i_cmd.wr_new) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_cmd.rd_prev | i_cmd.rd_head) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.pop) begin
                r_head <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new.key     <= i_key;
            r_new.tag     <= i_entry_tag;
            r_new.shopper <= i_shopper_flag;
            r_new.items   <= i_item_count;
            r_idx         <= r_count;
        end else if (i_cmd.wr_shift) begin
            r_idx <= r_idx - CW'(1);
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.resp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            o_status       <= i_cmd.resp_status;
            o_head_valid   <= i_cmd.resp_head;
            o_head_key     <= i_cmd.resp_head ? r_rd.key : '0;
            o_head_tag     <= i_cmd.resp_head ? r_rd.tag : '0;
            o_head_shopper <= i_cmd.resp_head ? r_rd.shopper : 1'b0;
            o_head_items   <= i_cmd.resp_head ? r_rd.items : '0;
            o_entry_count  <= COUNT_OUT_W'(n_count);
        end
    end

endmodule

FILE: rtl/core/spq_ctrl.sv
// command sequencer for insert walk and head read
module spq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [spq_pkg::CMD_W-1:0]     i_command,
    input  spq_pkg::t_dp_stat             i_stat,
    output spq_pkg::t_dp_cmd              o_cmd
);
    import spq_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_RD  = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_INS_PUT = 3'd3;
    localparam logic [2:0] S_HD_RD   = 3'd4;
    localparam logic [2:0] S_HD_OUT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_pop;
    logic       n_pop;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_pop   = r_pop;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_command)
                        CMD_INSERT: begin
                            if (i_stat.full) begin
                                o_cmd.resp        = 1'b1;
                                o_cmd.resp_status = ST_FULL;
                            end else begin
                                o_cmd.load = 1'b1;
                                n_state    = i_stat.empty ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (i_stat.empty) begin
                                o_cmd.resp        = 1'b1;
                                o_cmd.resp_status = ST_EMPTY;
                            end else begin
                                n_pop   = (i_command == CMD_POP);
                                n_state = S_HD_RD;
                            end
                        end
                        default: begin
                            o_cmd.resp        = 1'b1;
                            o_cmd.resp_status = ST_OK;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (i_stat.key_gt) begin
                    o_cmd.wr_shift = 1'b1;
                    n_state        = i_stat.idx_is_one ? S_INS_PUT : S_INS_RD;
                end else begin
                    o_cmd.wr_new      = 1'b1;
                    o_cmd.resp        = 1'b1;
                    o_cmd.resp_status = ST_OK;
                    n_state           = S_IDLE;
                end
            end
            S_INS_PUT: begin
                o_cmd.wr_new      = 1'b1;
                o_cmd.resp        = 1'b1;
                o_cmd.resp_status = ST_OK;
                n_state           = S_IDLE;
            end
            S_HD_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_HD_OUT;
            end
            S_HD_OUT: begin
                o_cmd.resp        = 1'b1;
                o_cmd.resp_status = ST_OK;
                o_cmd.resp_head   = 1'b1;
                o_cmd.pop         = r_pop;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pop   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pop   <= n_pop;
        end
    end

endmodule
